[design/rcs_pkg.sv]
package rcs_pkg;

    localparam int VALUE_IN_W  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int STACK_DEPTH = 32;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_PUSH,
        ST_ONE,
        ST_POP_RD,
        ST_POP_OUT
    } rcs_state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic push;
        logic pop_rd;
        logic out_single;
        logic out_pop;
    } rcs_cmd_t;

    typedef struct packed {
        logic radix_bad;
        logic quot_zero;
        logic bit_last;
        logic count_zero;
        logic out_free;
    } rcs_stat_t;

endpackage

[design/radix_converter_stack_core.sv]
// channel   handshake              payload
// convert   cvt_valid / cvt_stall  value, radix
// digits    dig_valid / dig_stall  digit, last, bad_radix
//
// each division by the radix runs on the bit-serial restoring divider, one dividend bit per step
// each digit then pops through the registered stack read port, in ST_POP_RD and then ST_POP_OUT
// a bad radix or a zero value gives one item after acceptance, through ST_CHECK and then ST_ONE
// rst_n clears the controller, counters and output valid; the stack needs no clearing
// a stalled digit holds the pop; a new value is taken as soon as the last digit is registered
module radix_converter_stack_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cvt_valid,
    output logic                           cvt_stall,
    input  logic [rcs_pkg::VALUE_IN_W-1:0] value,
    input  logic [rcs_pkg::RADIX_W-1:0]    radix,
    output logic                           dig_valid,
    input  logic                           dig_stall,
    output logic [rcs_pkg::DIGIT_W-1:0]    digit,
    output logic                           last,
    output logic                           bad_radix
);

    import rcs_pkg::*;

    rcs_cmd_t  cmd;
    rcs_stat_t stat;

    rcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cvt_valid (cvt_valid),
        .cvt_stall (cvt_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rcs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .radix     (radix),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .digit     (digit),
        .last      (last),
        .bad_radix (bad_radix),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[design/rcs_ram.sv]
module rcs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rcs_ctrl.sv]
module rcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cvt_valid,
    output logic              cvt_stall,
    input  rcs_pkg::rcs_stat_t stat,
    output rcs_pkg::rcs_cmd_t  cmd
);

    import rcs_pkg::*;

    rcs_state_t state_reg;
    rcs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cvt_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cvt_stall = 1'b0;
                if (cvt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.radix_bad || stat.quot_zero)
                begin
                    state_next = ST_ONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.bit_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (stat.quot_zero)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_ONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_single = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_pop = 1'b1;
                    state_next  = stat.count_zero ? ST_IDLE : ST_POP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/rcs_datapath.sv]
module rcs_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [rcs_pkg::VALUE_IN_W-1:0]       value,
    input  logic [rcs_pkg::RADIX_W-1:0]          radix,
    output logic                                 dig_valid,
    input  logic                                 dig_stall,
    output logic [rcs_pkg::DIGIT_W-1:0]          digit,
    output logic                                 last,
    output logic                                 bad_radix,
    input  rcs_pkg::rcs_cmd_t                    cmd,
    output rcs_pkg::rcs_stat_t                   stat
);

    import rcs_pkg::*;

    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [VALUE_WIDTH-1:0] quot_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [DIGIT_W-1:0]     rem_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DIGIT_W-1:0]     out_digit_reg;
    logic                   out_last_reg;
    logic                   out_bad_reg;

    logic [DIGIT_W:0]       rem_sh;
    logic                   ge;
    logic [DIGIT_W:0]       diff;
    logic                   stack_room;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [CNT_W-1:0]       count_dec;
    logic [DIGIT_W-1:0]     rd_data;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh     = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign ge         = rem_sh >= {1'b0, radix_reg};
    assign diff       = rem_sh - {1'b0, radix_reg};
    assign stack_room = count_reg < CNT_W'(STACK_DEPTH);
    assign count_dec  = count_reg - CNT_W'(1);
    assign wr_en      = cmd.push && stack_room;
    assign wr_addr    = count_reg[ADDR_W-1:0];
    assign rd_addr    = count_dec[ADDR_W-1:0];

    always_comb
    begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        if (cmd.load)
        begin
            quot_next  = VALUE_WIDTH'(value);
            count_next = '0;
        end
        if (cmd.div_init)
        begin
            rem_next     = '0;
            bit_cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            quot_next    = {quot_reg[VALUE_WIDTH-2:0], ge};
            rem_next     = ge ? diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end
        if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop_rd)
        begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg      <= '0;
            count_reg     <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            quot_reg      <= quot_next;
            count_reg     <= count_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            radix_reg <= radix;
        end
        if (cmd.out_single)
        begin
            out_digit_reg <= '0;
            out_last_reg  <= 1'b1;
            out_bad_reg   <= stat.radix_bad;
        end
        else if (cmd.out_pop)
        begin
            out_digit_reg <= rd_data;
            out_last_reg  <= stat.count_zero;
            out_bad_reg   <= 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && dig_stall;
        if (cmd.out_single || cmd.out_pop)
        begin
            out_valid_next = 1'b1;
        end
    end

    rcs_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rem_reg),
        .rd_en   (cmd.pop_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.radix_bad  = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
    assign stat.quot_zero  = quot_reg == '0;
    assign stat.bit_last   = bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1);
    assign stat.count_zero = count_reg == '0;
    assign stat.out_free   = !out_valid_reg || !dig_stall;

    assign dig_valid = out_valid_reg;
    assign digit     = out_digit_reg;
    assign last      = out_last_reg;
    assign bad_radix = out_bad_reg;

endmodule

[sim/rcs_checker.sv]
`timescale 1ns / 100ps

module rcs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cvt_valid,
    input  logic                           cvt_stall,
    input  logic [rcs_pkg::VALUE_IN_W-1:0] value,
    input  logic [rcs_pkg::RADIX_W-1:0]    radix,
    input  logic                           dig_valid,
    input  logic                           dig_stall,
    input  logic [rcs_pkg::DIGIT_W-1:0]    digit,
    input  logic                           last,
    input  logic                           bad_radix,
    output int                             mismatches,
    output int                             pending_digits,
    output int                             conversions,
    output int                             digits_checked
);

    import rcs_pkg::*;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               bad;
    } digit_rec_t;

    digit_rec_t                 expected_digits[$];
    logic [DIGIT_W-1:0]         digit_store[STACK_DEPTH];
    int                         store_count;
    logic [VALUE_WIDTH-1:0]     quotient;

    initial
    begin
        mismatches     = 0;
        pending_digits = 0;
        conversions    = 0;
        digits_checked = 0;
        store_count    = 0;
        quotient       = '0;
    end

    // repeated division, remainders stacked, then popped most significant first
    function automatic void predict_digits(input logic [VALUE_IN_W-1:0] v,
                                           input logic [RADIX_W-1:0] r);
        digit_rec_t rec;
        if (r < RADIX_MIN || r > RADIX_MAX)
        begin
            rec.digit = '0;
            rec.last  = 1'b1;
            rec.bad   = 1'b1;
            expected_digits.push_back(rec);
        end
        else
        begin
            quotient = VALUE_WIDTH'(v);
            if (quotient == '0)
            begin
                rec.digit = '0;
                rec.last  = 1'b1;
                rec.bad   = 1'b0;
                expected_digits.push_back(rec);
            end
            else
            begin
                store_count = 0;
                while (quotient != '0)
                begin
                    if (store_count < STACK_DEPTH)
                    begin
                        digit_store[store_count] = DIGIT_W'(quotient % VALUE_WIDTH'(r));
                        store_count++;
                    end
                    quotient = quotient / VALUE_WIDTH'(r);
                end
                while (store_count > 0)
                begin
                    store_count--;
                    rec.digit = digit_store[store_count];
                    rec.last  = (store_count == 0);
                    rec.bad   = 1'b0;
                    expected_digits.push_back(rec);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digit_rec_t want;
        if (!rst_n)
        begin
            expected_digits.delete();
            pending_digits = 0;
        end
        else
        begin
            if (dig_valid && !dig_stall)
            begin
                if (expected_digits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected digit %0d last %b bad_radix %b",
                                 $realtime, digit, last, bad_radix);
                end
                else
                begin
                    want = expected_digits.pop_front();
                    digits_checked++;
                    if (digit !== want.digit || last !== want.last || bad_radix !== want.bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: digit %0d last %b bad_radix %b, expected %0d %b %b",
                                     $realtime, digit, last, bad_radix,
                                     want.digit, want.last, want.bad);
                    end
                end
            end
            if (cvt_valid && !cvt_stall)
            begin
                predict_digits(value, radix);
                conversions++;
            end
            pending_digits = expected_digits.size();
        end
    end

endmodule

[sim/tb_radix_converter_stack_core.sv]
`timescale 1ns / 100ps

module tb_radix_converter_stack_core;

    import rcs_pkg::*;

    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 98;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cvt_valid = 1'b0;
    logic                  cvt_stall;
    logic [VALUE_IN_W-1:0] value     = '0;
    logic [RADIX_W-1:0]    radix     = '0;
    logic                  dig_valid;
    logic                  dig_stall = 1'b0;
    logic [DIGIT_W-1:0]    digit;
    logic                  last;
    logic                  bad_radix;
    logic                  idle_on   = 1'b1;

    int mismatches;
    int pending_digits;
    int conversions;
    int digits_checked;

    logic [VALUE_IN_W-1:0] dir_value[N_DIRECTED] = '{
        32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'd1, 32'd35, 32'd36, 32'd1, 32'd2, 32'h8000_0000, 32'd12345,
        32'd7, 32'd7, 32'd7, 32'd7, 32'h0, 32'hDEAD_BEEF, 32'd999, 32'd255, 32'd100
    };
    logic [RADIX_W-1:0] dir_radix[N_DIRECTED] = '{
        6'd10, 6'd2, 6'd36, 6'd2, 6'd36, 6'd16,
        6'd2, 6'd36, 6'd36, 6'd36, 6'd2, 6'd2, 6'd10,
        6'd0, 6'd1, 6'd37, 6'd63, 6'd0, 6'd8, 6'd3, 6'd16, 6'd7
    };

    radix_converter_stack_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cvt_valid (cvt_valid),
        .cvt_stall (cvt_stall),
        .value     (value),
        .radix     (radix),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .digit     (digit),
        .last      (last),
        .bad_radix (bad_radix)
    );

    rcs_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cvt_valid      (cvt_valid),
        .cvt_stall      (cvt_stall),
        .value          (value),
        .radix          (radix),
        .dig_valid      (dig_valid),
        .dig_stall      (dig_stall),
        .digit          (digit),
        .last           (last),
        .bad_radix      (bad_radix),
        .mismatches     (mismatches),
        .pending_digits (pending_digits),
        .conversions    (conversions),
        .digits_checked (digits_checked)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        dig_stall <= idle_on && ($urandom_range(99) < 20);
    end

    // returns at the edge that takes the item
    task automatic send_conversion(input logic [VALUE_IN_W-1:0] v, input logic [RADIX_W-1:0] r);
        while (idle_on && $urandom_range(99) < 20)
        begin
            cvt_valid <= 1'b0;
            @(posedge clk);
        end
        cvt_valid <= 1'b1;
        value     <= v;
        radix     <= r;
        @(negedge clk);
        while (cvt_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        logic [VALUE_IN_W-1:0] v;
        logic [RADIX_W-1:0]    r;
        int                    pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_conversion(dir_value[i], dir_radix[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 40)
                idle_on <= 1'b0;
            if (n == 80)
                idle_on <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                if ($urandom_range(1))
                    r = RADIX_W'($urandom_range(RADIX_MIN - 1, 0));
                else
                    r = RADIX_W'($urandom_range((1 << RADIX_W) - 1, RADIX_MAX + 1));
            end
            else
                r = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
            if (pick >= 8 && pick < 15)
                v = '0;
            else if (pick < 60)
                v = $urandom >> $urandom_range(VALUE_IN_W - 1, 0);
            else
                v = $urandom;
            send_conversion(v, r);
        end

        cvt_valid <= 1'b0;
        @(negedge clk);
        wait (pending_digits == 0);
        repeat (50) @(posedge clk);

        $display("%0d conversions sent (directed edge values, bad radices, random values)",
                 conversions);
        $display("%0d digits compared, %0d mismatches", digits_checked, mismatches);
        if (mismatches == 0 && pending_digits == 0)
            $display("tb_radix_converter_stack_core: PASS");
        else
            $display("tb_radix_converter_stack_core: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_radix_converter_stack_core: FAIL");
        $finish;
    end

endmodule

[sim.f]
design/rcs_pkg.sv
design/rcs_ram.sv
design/rcs_ctrl.sv
design/rcs_datapath.sv
design/radix_converter_stack_core.sv
sim/rcs_checker.sv
sim/tb_radix_converter_stack_core.sv
